### src/flac_fhp_pkg.sv
package flac_fhp_pkg;

    // Status codes carried on the result side-band.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_SYNC   = 2'd1;
    localparam logic [1:0] ST_BAD_RATE   = 2'd2;
    localparam logic [1:0] ST_BAD_NUMBER = 2'd3;

    // Sample-rate codes that pull in an extra header field, and the reserved one.
    localparam logic [3:0] RATE_KHZ8     = 4'd12;
    localparam logic [3:0] RATE_HZ16     = 4'd13;
    localparam logic [3:0] RATE_DAHZ16   = 4'd14;
    localparam logic [3:0] RATE_RESERVED = 4'd15;

    // Block-size codes that pull in an extra 8 or 16 bit field.
    localparam logic [3:0] BS_EXTRA8     = 4'd6;
    localparam logic [3:0] BS_EXTRA16    = 4'd7;

    // Channel modes.
    localparam logic [2:0] MODE_INDEPENDENT = 3'd0;
    localparam logic [2:0] MODE_INVALID     = 3'd4;

    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [5:0] SYNC_SECOND = 6'h3E;

    localparam int TDATA_W = 104;

    typedef enum logic [10:0] {
        PH_IDLE  = 11'b000_0000_0001,
        PH_SYNC2 = 11'b000_0000_0010,
        PH_CODES = 11'b000_0000_0100,
        PH_CHAN  = 11'b000_0000_1000,
        PH_NLEAD = 11'b000_0001_0000,
        PH_NCONT = 11'b000_0010_0000,
        PH_BS_HI = 11'b000_0100_0000,
        PH_BS_LO = 11'b000_1000_0000,
        PH_SR_HI = 11'b001_0000_0000,
        PH_SR_LO = 11'b010_0000_0000,
        PH_CRC   = 11'b100_0000_0000
    } phase_t;

    // Result payload, laid out exactly as it travels on tdata (lowest field last).
    typedef struct packed {
        logic [5:0]  pad;
        logic [7:0]  crc_byte;
        logic [4:0]  sample_size;
        logic [3:0]  num_channels;
        logic [2:0]  channel_mode;
        logic [3:0]  channel_assignment;
        logic [19:0] sample_rate;
        logic [16:0] block_size;
        logic [35:0] coded_number;
        logic        blocking_variable;
    } result_t;

    function automatic logic [19:0] rate_lookup(input logic [3:0] code);
        logic [19:0] hz;
        case (code)
            4'd1:    hz = 20'd88200;
            4'd2:    hz = 20'd176400;
            4'd3:    hz = 20'd192000;
            4'd4:    hz = 20'd8000;
            4'd5:    hz = 20'd16000;
            4'd6:    hz = 20'd22050;
            4'd7:    hz = 20'd24000;
            4'd8:    hz = 20'd32000;
            4'd9:    hz = 20'd44100;
            4'd10:   hz = 20'd48000;
            4'd11:   hz = 20'd96000;
            default: hz = 20'd0;
        endcase
        return hz;
    endfunction

    function automatic logic [4:0] size_lookup(input logic [2:0] code);
        logic [4:0] bits;
        case (code)
            3'd1:    bits = 5'd8;
            3'd2:    bits = 5'd12;
            3'd4:    bits = 5'd16;
            3'd5:    bits = 5'd20;
            3'd6:    bits = 5'd24;
            default: bits = 5'd0;
        endcase
        return bits;
    endfunction

    // Block size for the codes that need no extra field.
    function automatic logic [16:0] block_lookup(input logic [3:0] code);
        logic [16:0] n;
        case (code)
            4'd1:    n = 17'd192;
            4'd2:    n = 17'd576;
            4'd3:    n = 17'd1152;
            4'd4:    n = 17'd2304;
            4'd5:    n = 17'd4608;
            4'd8:    n = 17'd256;
            4'd9:    n = 17'd512;
            4'd10:   n = 17'd1024;
            4'd11:   n = 17'd2048;
            4'd12:   n = 17'd4096;
            4'd13:   n = 17'd8192;
            4'd14:   n = 17'd16384;
            4'd15:   n = 17'd32768;
            default: n = 17'd0;
        endcase
        return n;
    endfunction

    function automatic phase_t rate_phase(input logic [3:0] code);
        phase_t ph;
        if (code == RATE_KHZ8) begin
            ph = PH_SR_LO;
        end
        else if (code == RATE_HZ16 || code == RATE_DAHZ16) begin
            ph = PH_SR_HI;
        end
        else begin
            ph = PH_CRC;
        end
        return ph;
    endfunction

    function automatic phase_t number_done_phase(input logic [3:0] bs_code,
                                                 input logic [3:0] rt_code);
        phase_t ph;
        if (bs_code == BS_EXTRA8) begin
            ph = PH_BS_LO;
        end
        else if (bs_code == BS_EXTRA16) begin
            ph = PH_BS_HI;
        end
        else begin
            ph = rate_phase(rt_code);
        end
        return ph;
    endfunction

endpackage

### src/flac_frame_header_parser_top.sv
// Output: a result beat is presented in the cycle after the header's CRC byte is accepted
// (or after the second byte when the sync word is bad).
// Throughput: one header byte per cycle; a waiting result never blocks input unless the
// output register is full and the sink is not ready.
// Reset: rst_n is asynchronous and active low; it returns the parser to idle and empties
// the output register.
module flac_frame_header_parser_top
    import flac_fhp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Header byte stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] byte_value
    input  logic                 s_tuser,   // [0] header_start
    // Decoded header results.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] blocking_variable, [36:1] coded_number, [53:37] block_size,
    // [73:54] sample_rate, [77:74] channel_assignment, [80:78] channel_mode,
    // [84:81] num_channels, [89:85] sample_size, [97:90] crc_byte, [103:98] zero
    output logic [TDATA_W-1:0]   m_tdata,
    output logic [1:0]           m_tuser    // [1:0] status
);

    // Parse state. Each accepted byte holds the phase, moves it to one next phase, or
    // finishes a header, so the whole update is a small amount of logic per cycle.
    phase_t      phase_reg,    phase_next;
    logic        blocking_reg, blocking_next;
    logic [3:0]  bs_code_reg,  bs_code_next;
    logic [3:0]  rate_code_reg, rate_code_next;
    logic [3:0]  chan_code_reg, chan_code_next;
    logic [2:0]  size_code_reg, size_code_next;
    logic [35:0] number_reg,   number_next;
    logic [2:0]  cont_reg,     cont_next;
    logic [15:0] extra_reg,    extra_next;
    logic [1:0]  error_reg,    error_next;
    logic [16:0] block_reg,    block_next;

    // Output register: it holds one finished result until the sink takes it; while
    // it is full and the sink is not ready, the input side stalls.
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg,  out_data_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic        in_beat;
    logic        emit;
    logic [7:0]  b;

    // Number lead-byte decode.
    logic [35:0] lead_value;
    logic [2:0]  lead_cont;
    logic        lead_bad;
    logic [2:0]  cont_dec;

    // Result assembly for the CRC byte.
    logic [1:0]  res_status;
    logic [19:0] res_rate;
    logic [2:0]  res_mode;
    logic [3:0]  res_nch;
    logic [25:0] khz_product;

    assign b        = s_tdata;
    assign s_tready = !out_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign cont_dec = cont_reg - 3'd1;

    // The coded number uses the UTF-8 layout: a first byte below 0x80 stands alone,
    // else its leading ones, less one, count the continuation bytes that follow.
    always_comb
    begin
        lead_value = 36'd0;
        lead_cont  = 3'd0;
        lead_bad   = 1'b0;
        if (!b[7]) begin
            lead_value = {28'd0, b};
        end
        else if (!b[6]) begin
            lead_bad = 1'b1;
        end
        else if (!b[5]) begin
            lead_value = {31'd0, b[4:0]};
            lead_cont  = 3'd1;
        end
        else if (!b[4]) begin
            lead_value = {32'd0, b[3:0]};
            lead_cont  = 3'd2;
        end
        else if (!b[3]) begin
            lead_value = {33'd0, b[2:0]};
            lead_cont  = 3'd3;
        end
        else if (!b[2]) begin
            lead_value = {34'd0, b[1:0]};
            lead_cont  = 3'd4;
        end
        else if (!b[1]) begin
            lead_value = {35'd0, b[0]};
            lead_cont  = 3'd5;
        end
        else if (!b[0] && blocking_reg) begin
            // The seven-byte form only exists for sample numbers.
            lead_cont = 3'd6;
        end
        else begin
            lead_bad = 1'b1;
        end
    end

    // Fields of the result that depend only on the latched codes, extra field and error.
    always_comb
    begin
        khz_product = {10'd0, extra_reg} * 26'd1000;
        if (error_reg == ST_BAD_NUMBER) begin
            res_status = ST_BAD_NUMBER;
        end
        else if (rate_code_reg == RATE_RESERVED) begin
            res_status = ST_BAD_RATE;
        end
        else begin
            res_status = ST_OK;
        end

        if (rate_code_reg == RATE_KHZ8) begin
            res_rate = khz_product[19:0];
        end
        else if (rate_code_reg == RATE_HZ16) begin
            res_rate = {4'd0, extra_reg};
        end
        else if (rate_code_reg == RATE_DAHZ16) begin
            res_rate = {4'd0, extra_reg} * 20'd10;
        end
        else begin
            res_rate = rate_lookup(rate_code_reg);
        end

        // Codes 0 to 7 are independent channels, 8 to 10 the stereo
        // decorrelation modes, and the rest are invalid.
        if (!chan_code_reg[3]) begin
            res_mode = MODE_INDEPENDENT;
            res_nch  = chan_code_reg + 4'd1;
        end
        else if (chan_code_reg <= 4'd10) begin
            res_mode = 3'(chan_code_reg - 4'd7);
            res_nch  = 4'd2;
        end
        else begin
            res_mode = MODE_INVALID;
            res_nch  = 4'd0;
        end
    end

    // Next-state logic for the parser and the output register.
    always_comb
    begin
        phase_next      = phase_reg;
        blocking_next   = blocking_reg;
        bs_code_next    = bs_code_reg;
        rate_code_next  = rate_code_reg;
        chan_code_next  = chan_code_reg;
        size_code_next  = size_code_reg;
        number_next     = number_reg;
        cont_next       = cont_reg;
        extra_next      = extra_reg;
        error_next      = error_reg;
        block_next      = block_reg;
        emit            = 1'b0;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;

        if (in_beat) begin
            if (s_tuser) begin
                // A header start always restarts, abandoning any header in flight.
                phase_next     = PH_SYNC2;
                blocking_next  = 1'b0;
                bs_code_next   = 4'd0;
                rate_code_next = 4'd0;
                chan_code_next = 4'd0;
                size_code_next = 3'd0;
                number_next    = 36'd0;
                cont_next      = 3'd0;
                extra_next     = 16'd0;
                block_next     = 17'd0;
                error_next     = (b != SYNC_FIRST) ? ST_BAD_SYNC : ST_OK;
            end
            else begin
                case (phase_reg)
                    PH_SYNC2:
                    begin
                        if (error_reg != ST_OK || b[7:2] != SYNC_SECOND) begin
                            // Bad sync reports at once with every other field zero.
                            emit            = 1'b1;
                            out_data_next   = '0;
                            out_status_next = ST_BAD_SYNC;
                        end
                        else begin
                            blocking_next = b[0];
                            phase_next    = PH_CODES;
                        end
                    end
                    PH_CODES:
                    begin
                        bs_code_next   = b[7:4];
                        rate_code_next = b[3:0];
                        phase_next     = PH_CHAN;
                    end
                    PH_CHAN:
                    begin
                        chan_code_next = b[7:4];
                        size_code_next = b[3:1];
                        phase_next     = PH_NLEAD;
                    end
                    PH_NLEAD:
                    begin
                        if (lead_bad) begin
                            if (error_reg == ST_OK) begin
                                error_next = ST_BAD_NUMBER;
                            end
                            number_next = 36'd0;
                            cont_next   = 3'd0;
                        end
                        else begin
                            number_next = lead_value;
                            cont_next   = lead_cont;
                        end
                        if (lead_bad || lead_cont == 3'd0) begin
                            extra_next = 16'd0;
                            if (bs_code_reg != BS_EXTRA8 && bs_code_reg != BS_EXTRA16) begin
                                block_next = block_lookup(bs_code_reg);
                            end
                            phase_next = number_done_phase(bs_code_reg, rate_code_reg);
                        end
                        else begin
                            phase_next = PH_NCONT;
                        end
                    end
                    PH_NCONT:
                    begin
                        if (b[7:6] != 2'b10) begin
                            // A broken continuation ends the number and is consumed.
                            if (error_reg == ST_OK) begin
                                error_next = ST_BAD_NUMBER;
                            end
                            number_next = 36'd0;
                            cont_next   = 3'd0;
                        end
                        else begin
                            number_next = {number_reg[29:0], b[5:0]};
                            cont_next   = cont_dec;
                        end
                        if (b[7:6] != 2'b10 || cont_dec == 3'd0) begin
                            extra_next = 16'd0;
                            if (bs_code_reg != BS_EXTRA8 && bs_code_reg != BS_EXTRA16) begin
                                block_next = block_lookup(bs_code_reg);
                            end
                            phase_next = number_done_phase(bs_code_reg, rate_code_reg);
                        end
                    end
                    PH_BS_HI, PH_SR_HI:
                    begin
                        extra_next = {8'd0, b};
                        phase_next = (phase_reg == PH_BS_HI) ? PH_BS_LO : PH_SR_LO;
                    end
                    PH_BS_LO:
                    begin
                        // The field holds the block size minus one.
                        block_next = {1'b0, extra_reg[7:0], b} + 17'd1;
                        extra_next = 16'd0;
                        phase_next = rate_phase(rate_code_reg);
                    end
                    PH_SR_LO:
                    begin
                        extra_next = {extra_reg[7:0], b};
                        phase_next = PH_CRC;
                    end
                    PH_CRC:
                    begin
                        emit                             = 1'b1;
                        out_status_next                  = res_status;
                        out_data_next.pad                = '0;
                        out_data_next.crc_byte           = b;
                        out_data_next.sample_size        = size_lookup(size_code_reg);
                        out_data_next.num_channels       = res_nch;
                        out_data_next.channel_mode       = res_mode;
                        out_data_next.channel_assignment = chan_code_reg;
                        out_data_next.sample_rate        = res_rate;
                        out_data_next.block_size         = block_reg;
                        out_data_next.coded_number       =
                            (res_status == ST_BAD_NUMBER) ? 36'd0 : number_reg;
                        out_data_next.blocking_variable  = blocking_reg;
                    end
                    default:
                    begin
                        // Idle: bytes outside a header are dropped.
                    end
                endcase

                if (emit) begin
                    phase_next     = PH_IDLE;
                    blocking_next  = 1'b0;
                    bs_code_next   = 4'd0;
                    rate_code_next = 4'd0;
                    chan_code_next = 4'd0;
                    size_code_next = 3'd0;
                    number_next    = 36'd0;
                    cont_next      = 3'd0;
                    extra_next     = 16'd0;
                    error_next     = ST_OK;
                    block_next     = 17'd0;
                end
            end
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end
        else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_IDLE;
            blocking_reg   <= 1'b0;
            bs_code_reg    <= 4'd0;
            rate_code_reg  <= 4'd0;
            chan_code_reg  <= 4'd0;
            size_code_reg  <= 3'd0;
            number_reg     <= 36'd0;
            cont_reg       <= 3'd0;
            extra_reg      <= 16'd0;
            error_reg      <= ST_OK;
            block_reg      <= 17'd0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            phase_reg      <= phase_next;
            blocking_reg   <= blocking_next;
            bs_code_reg    <= bs_code_next;
            rate_code_reg  <= rate_code_next;
            chan_code_reg  <= chan_code_next;
            size_code_reg  <= size_code_next;
            number_reg     <= number_next;
            cont_reg       <= cont_next;
            extra_reg      <= extra_next;
            error_reg      <= error_next;
            block_reg      <= block_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload carries no reset; it is only looked at while valid.
    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    // A bad-sync result carries nothing but its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_BAD_SYNC) |-> (out_data_reg == '0))
        else $error("bad-sync result with nonzero payload");

    // A malformed number never leaks a partial value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_BAD_NUMBER)
            |-> (out_data_reg.coded_number == 36'd0))
        else $error("malformed number result with nonzero coded number");

    // The CRC byte finishes the header and returns the parser to idle with a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !s_tuser && phase_reg == PH_CRC)
            |=> (phase_reg == PH_IDLE && out_valid_reg))
        else $error("CRC byte did not complete the header");

    // A header start always lands in the second sync byte phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_tuser) |=> (phase_reg == PH_SYNC2))
        else $error("header start did not restart the parse");

    // Continuation bytes are only outstanding while the number is being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NCONT) |-> (cont_reg != 3'd0))
        else $error("continuation phase with no bytes left");
`endif

endmodule

### tb/sv/tb.sv
module tb;
    import flac_fhp_pkg::*;

    // Shape of the stimulus and of the receiver's stall pattern.
    localparam int RANDOM_BEATS = 1050;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AFTER   = 20;
    localparam int HOLD_CYCLES  = 400;

    // Flaws that can be planted in the coded number of a generated header.
    localparam int FLAW_NONE = 0;
    localparam int FLAW_LEAD = 1;
    localparam int FLAW_CONT = 2;

    // How the free bits of a generated header are filled.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;

    // Receiver readiness modes.
    localparam int RX_ALWAYS = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;

    // One beat of the header byte stream.
    typedef struct packed {
        logic       start;
        logic [7:0] value;
    } header_beat_t;

    // One decoded header as it should come out: status on tuser, the rest on tdata.
    typedef struct packed {
        logic [1:0] status;
        result_t    fields;
    } header_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;

    header_beat_t        pending_beats[$];
    header_result_t      expected_headers[$];
    header_beat_t        next_beat;
    header_result_t      want;
    result_t             got;

    int                  fail_count;
    int                  ignored_beats;
    int                  results_seen;
    int                  burst_left;
    int                  gap_left;
    int                  idle_cycles;
    int                  ready_mode;
    int                  mode_left;
    int                  hold_left;
    int                  sparse_count;
    bit                  hold_done;

    // Our own copy of the parser state, updated once per accepted input beat.
    phase_t              hdr_phase;
    logic                hdr_variable;
    logic [3:0]          hdr_bs_code;
    logic [3:0]          hdr_rate_code;
    logic [3:0]          hdr_chan_code;
    logic [2:0]          hdr_size_code;
    logic [35:0]         hdr_number;
    logic [2:0]          hdr_cont_left;
    logic [15:0]         hdr_extra;
    logic [1:0]          hdr_err;
    logic [16:0]         hdr_block;

    flac_frame_header_parser_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Header predictor.
    // ------------------------------------------------------------------

    task automatic clear_parser();
        hdr_phase     = PH_IDLE;
        hdr_variable  = 1'b0;
        hdr_bs_code   = '0;
        hdr_rate_code = '0;
        hdr_chan_code = '0;
        hdr_size_code = '0;
        hdr_number    = '0;
        hdr_cont_left = '0;
        hdr_extra     = '0;
        hdr_err       = ST_OK;
        hdr_block     = '0;
    endtask

    // Sample-rate codes 12..14 pull in one or two more bytes before the CRC.
    task automatic enter_rate_field();
        hdr_extra = '0;
        if (hdr_rate_code == RATE_KHZ8)
        begin
            hdr_phase = PH_SR_LO;
        end
        else if (hdr_rate_code == RATE_HZ16 || hdr_rate_code == RATE_DAHZ16)
        begin
            hdr_phase = PH_SR_HI;
        end
        else
        begin
            hdr_phase = PH_CRC;
        end
    endtask

    // The coded number is complete: settle the block size and pick the next field.
    task automatic finish_number();
        logic [3:0] c;
        c = hdr_bs_code;
        hdr_extra = '0;
        if (c == 4'd0)
        begin
            hdr_block = '0;
        end
        else if (c == 4'd1)
        begin
            hdr_block = 17'd192;
        end
        else if (c >= 4'd2 && c <= 4'd5)
        begin
            hdr_block = 17'd576 << (c - 4'd2);
        end
        else if (c >= 4'd8)
        begin
            hdr_block = 17'd256 << (c - 4'd8);
        end
        if (c == BS_EXTRA8)
        begin
            hdr_phase = PH_BS_LO;
        end
        else if (c == BS_EXTRA16)
        begin
            hdr_phase = PH_BS_HI;
        end
        else
        begin
            enter_rate_field();
        end
    endtask

    // A bad sync seen first keeps its status; otherwise the number error wins.
    task automatic number_fault();
        if (hdr_err == ST_OK)
        begin
            hdr_err = ST_BAD_NUMBER;
        end
        hdr_number    = '0;
        hdr_cont_left = '0;
    endtask

    task automatic absorb_header_byte(input logic [7:0] b, input logic start);
        header_result_t r;
        logic [31:0]    hz;
        logic [3:0]     ch;
        if (start)
        begin
            // A start beat always restarts, even in the middle of a header.
            clear_parser();
            if (b != SYNC_FIRST)
            begin
                hdr_err = ST_BAD_SYNC;
            end
            hdr_phase = PH_SYNC2;
        end
        else
        begin
            case (hdr_phase)
                PH_SYNC2:
                begin
                    if (hdr_err != ST_OK || b[7:2] != SYNC_SECOND)
                    begin
                        r = '0;
                        r.status = ST_BAD_SYNC;
                        expected_headers.push_back(r);
                        clear_parser();
                    end
                    else
                    begin
                        hdr_variable = b[0];
                        hdr_phase = PH_CODES;
                    end
                end
                PH_CODES:
                begin
                    hdr_bs_code   = b[7:4];
                    hdr_rate_code = b[3:0];
                    hdr_phase     = PH_CHAN;
                end
                PH_CHAN:
                begin
                    hdr_chan_code = b[7:4];
                    hdr_size_code = b[3:1];
                    hdr_phase     = PH_NLEAD;
                end
                PH_NLEAD:
                begin
                    hdr_cont_left = '0;
                    if (b < 8'h80)
                    begin
                        hdr_number = {28'd0, b};
                    end
                    else if (b < 8'hC0)
                    begin
                        number_fault();
                    end
                    else if (b < 8'hE0)
                    begin
                        hdr_number = {31'd0, b[4:0]};
                        hdr_cont_left = 3'd1;
                    end
                    else if (b < 8'hF0)
                    begin
                        hdr_number = {32'd0, b[3:0]};
                        hdr_cont_left = 3'd2;
                    end
                    else if (b < 8'hF8)
                    begin
                        hdr_number = {33'd0, b[2:0]};
                        hdr_cont_left = 3'd3;
                    end
                    else if (b < 8'hFC)
                    begin
                        hdr_number = {34'd0, b[1:0]};
                        hdr_cont_left = 3'd4;
                    end
                    else if (b < 8'hFE)
                    begin
                        hdr_number = {35'd0, b[0]};
                        hdr_cont_left = 3'd5;
                    end
                    else if (b == 8'hFE && hdr_variable)
                    begin
                        hdr_number = '0;
                        hdr_cont_left = 3'd6;
                    end
                    else
                    begin
                        number_fault();
                    end
                    if (hdr_cont_left == 3'd0)
                    begin
                        finish_number();
                    end
                    else
                    begin
                        hdr_phase = PH_NCONT;
                    end
                end
                PH_NCONT:
                begin
                    // A byte that is not a continuation ends the number and is eaten.
                    if (b[7:6] != 2'b10)
                    begin
                        number_fault();
                        finish_number();
                    end
                    else
                    begin
                        hdr_number = {hdr_number[29:0], b[5:0]};
                        hdr_cont_left = hdr_cont_left - 3'd1;
                        if (hdr_cont_left == 3'd0)
                        begin
                            finish_number();
                        end
                    end
                end
                PH_BS_HI:
                begin
                    hdr_extra = {8'd0, b};
                    hdr_phase = PH_BS_LO;
                end
                PH_BS_LO:
                begin
                    hdr_extra = {hdr_extra[7:0], b};
                    hdr_block = {1'b0, hdr_extra} + 17'd1;
                    enter_rate_field();
                end
                PH_SR_HI:
                begin
                    hdr_extra = {8'd0, b};
                    hdr_phase = PH_SR_LO;
                end
                PH_SR_LO:
                begin
                    hdr_extra = {hdr_extra[7:0], b};
                    hdr_phase = PH_CRC;
                end
                PH_CRC:
                begin
                    r = '0;
                    if (hdr_err == ST_BAD_NUMBER)
                    begin
                        r.status = ST_BAD_NUMBER;
                    end
                    else if (hdr_rate_code == RATE_RESERVED)
                    begin
                        r.status = ST_BAD_RATE;
                    end
                    else
                    begin
                        r.status = ST_OK;
                    end
                    case (hdr_rate_code)
                        4'd1:        hz = 32'd88200;
                        4'd2:        hz = 32'd176400;
                        4'd3:        hz = 32'd192000;
                        4'd4:        hz = 32'd8000;
                        4'd5:        hz = 32'd16000;
                        4'd6:        hz = 32'd22050;
                        4'd7:        hz = 32'd24000;
                        4'd8:        hz = 32'd32000;
                        4'd9:        hz = 32'd44100;
                        4'd10:       hz = 32'd48000;
                        4'd11:       hz = 32'd96000;
                        RATE_KHZ8:   hz = hdr_extra * 32'd1000;
                        RATE_HZ16:   hz = {16'd0, hdr_extra};
                        RATE_DAHZ16: hz = hdr_extra * 32'd10;
                        default:     hz = 32'd0;
                    endcase
                    ch = hdr_chan_code;
                    if (ch <= 4'd7)
                    begin
                        r.fields.channel_mode = MODE_INDEPENDENT;
                        r.fields.num_channels = ch + 4'd1;
                    end
                    else if (ch <= 4'd10)
                    begin
                        r.fields.channel_mode = 3'(ch - 4'd7);
                        r.fields.num_channels = 4'd2;
                    end
                    else
                    begin
                        r.fields.channel_mode = MODE_INVALID;
                        r.fields.num_channels = 4'd0;
                    end
                    case (hdr_size_code)
                        3'd1:    r.fields.sample_size = 5'd8;
                        3'd2:    r.fields.sample_size = 5'd12;
                        3'd4:    r.fields.sample_size = 5'd16;
                        3'd5:    r.fields.sample_size = 5'd20;
                        3'd6:    r.fields.sample_size = 5'd24;
                        default: r.fields.sample_size = 5'd0;
                    endcase
                    r.fields.blocking_variable  = hdr_variable;
                    r.fields.coded_number       = (r.status == ST_BAD_NUMBER) ? '0 : hdr_number;
                    r.fields.block_size         = hdr_block;
                    r.fields.sample_rate        = hz[19:0];
                    r.fields.channel_assignment = ch;
                    r.fields.crc_byte           = b;
                    expected_headers.push_back(r);
                    clear_parser();
                end
                default:
                begin
                    // Idle: bytes that do not start a header are dropped.
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b, input logic start);
        header_beat_t beat;
        beat.start = start;
        beat.value = b;
        pending_beats.push_back(beat);
    endtask

    function automatic logic [7:0] content_byte(input int fill);
        logic [7:0] v;
        if (fill == FILL_ZEROS)
        begin
            v = 8'h00;
        end
        else if (fill == FILL_ONES)
        begin
            v = 8'hFF;
        end
        else
        begin
            v = 8'($urandom);
        end
        return v;
    endfunction

    // Queues one header: sync, the code bytes, the coded number (possibly flawed),
    // whatever extra fields the codes ask for, and the CRC byte.
    task automatic push_header(input logic [7:0] sync2, input logic [7:0] codes,
                               input logic [7:0] chan_byte, input int num_len,
                               input int flaw, input int fill);
        logic [7:0] lead;
        logic [7:0] fb;
        int         bad_at;
        int         i;
        bit         stopped;
        push_byte(SYNC_FIRST, 1'b1);
        push_byte(sync2, 1'b0);
        push_byte(codes, 1'b0);
        push_byte(chan_byte, 1'b0);
        fb = content_byte(fill);
        if (flaw == FLAW_LEAD)
        begin
            // A stray continuation, 0xFF, or 0xFE where blocking is fixed.
            case ($urandom_range(0, 2))
                0:       lead = {2'b10, fb[5:0]};
                1:       lead = 8'hFF;
                default: lead = sync2[0] ? 8'hFF : 8'hFE;
            endcase
            push_byte(lead, 1'b0);
        end
        else
        begin
            if (num_len <= 1)
            begin
                lead = {1'b0, fb[6:0]};
            end
            else
            begin
                lead = (8'hFF << (8 - num_len)) | (fb & (8'hFF >> (num_len + 1)));
            end
            push_byte(lead, 1'b0);
            bad_at = (flaw == FLAW_CONT && num_len > 1) ? $urandom_range(1, num_len - 1) : 0;
            stopped = 1'b0;
            for (i = 1; i < num_len && !stopped; i++)
            begin
                fb = content_byte(fill);
                if (i == bad_at)
                begin
                    push_byte({fb[7] ? 2'b11 : {1'b0, fb[6]}, fb[5:0]}, 1'b0);
                    stopped = 1'b1;
                end
                else
                begin
                    push_byte({2'b10, fb[5:0]}, 1'b0);
                end
            end
        end
        if (codes[7:4] == BS_EXTRA8 || codes[7:4] == BS_EXTRA16)
        begin
            push_byte(content_byte(fill), 1'b0);
        end
        if (codes[7:4] == BS_EXTRA16)
        begin
            push_byte(content_byte(fill), 1'b0);
        end
        if (codes[3:0] == RATE_KHZ8 || codes[3:0] == RATE_HZ16 || codes[3:0] == RATE_DAHZ16)
        begin
            push_byte(content_byte(fill), 1'b0);
        end
        if (codes[3:0] == RATE_HZ16 || codes[3:0] == RATE_DAHZ16)
        begin
            push_byte(content_byte(fill), 1'b0);
        end
        push_byte(content_byte(fill), 1'b0);
    endtask

    task automatic build_stimulus();
        int  pick;
        int  len;
        int  flaw;
        int  k;
        bit  parser_idle;
        logic [7:0] sync2;

        // Directed part. Bytes without a start beat while idle must be dropped.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        ignored_beats = 2;
        // Bad sync in the first byte, then in the second byte.
        push_byte(8'h7F, 1'b1);
        push_byte(8'hF8, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        // A header abandoned after three bytes by the next start beat.
        push_byte(8'hFF, 1'b1);
        push_byte(8'hF9, 1'b0);
        push_byte(8'h00, 1'b0);
        // Reserved rate together with a malformed number: number error wins.
        push_header(8'hF8, 8'h1F, 8'h00, 1, FLAW_LEAD, FILL_ZEROS);
        // Every field at its top: seven-byte number, 16-bit block size, kHz rate.
        push_header(8'hFB, 8'h7C, 8'hFF, 7, FLAW_NONE, FILL_ONES);
        // Bad continuation byte with an 8-bit block size and a 16-bit rate field behind it.
        push_header(8'hFA, 8'h6E, 8'hA8, 3, FLAW_CONT, FILL_RANDOM);

        // Random part: mostly well-formed headers with random content.
        parser_idle = 1'b1;
        while (pending_beats.size() - ignored_beats < RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                sync2 = {SYNC_SECOND, 2'($urandom)};
                len = sync2[0] ? $urandom_range(1, 7) : $urandom_range(1, 6);
                k = $urandom_range(0, 9);
                if (k == 0)
                begin
                    flaw = FLAW_LEAD;
                end
                else if (k == 1 && len > 1)
                begin
                    flaw = FLAW_CONT;
                end
                else
                begin
                    flaw = FLAW_NONE;
                end
                push_header(sync2, 8'($urandom), 8'($urandom), len, flaw, FILL_RANDOM);
                parser_idle = 1'b1;
            end
            else if (pick < 85)
            begin
                // Truncated header; the next start beat cuts it off.
                push_byte(SYNC_FIRST, 1'b1);
                push_byte({SYNC_SECOND, 2'($urandom)}, 1'b0);
                k = $urandom_range(1, 6);
                repeat (k) push_byte(8'($urandom), 1'b0);
                parser_idle = 1'b0;
            end
            else if (pick < 92)
            begin
                // Broken sync words.
                push_byte(($urandom_range(0, 1) == 0) ? SYNC_FIRST : 8'($urandom), 1'b1);
                push_byte(8'($urandom), 1'b0);
                parser_idle = 1'b0;
            end
            else if (parser_idle)
            begin
                k = $urandom_range(1, 4);
                repeat (k) push_byte(8'($urandom), 1'b0);
                ignored_beats += k;
            end
            else
            begin
                push_byte(8'($urandom), 1'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the pending beats in bursts of random length, with random
    // gaps between the bursts, and feeds every accepted beat to the predictor.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                absorb_header_byte(s_tdata, s_tuser);
            end
            // The beat on the bus may only change once it has been taken.
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    next_beat = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_beat.value;
                    s_tuser  <= next_beat.start;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // A quarter of the bursts run straight into the next one.
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switches between readiness patterns at random intervals, and once,
    // after a number of results, holds off for a long stretch so the output
    // register fills and the parser has to stall its input.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            ready_mode   = RX_ALWAYS;
            mode_left    = 0;
            hold_left    = 0;
            hold_done    = 1'b0;
            sparse_count = 0;
        end
        else
        begin
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                sparse_count++;
                case (ready_mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    default:   m_tready <= (sparse_count % 4 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result beat is checked against the oldest predicted header.
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            got = m_tdata;
            if (expected_headers.size() == 0)
            begin
                $error("result beat with no header pending, status %0d", m_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_headers.pop_front();
                check_field("status", 64'(want.status), 64'(m_tuser));
                check_field("blocking_variable", 64'(want.fields.blocking_variable),
                            64'(got.blocking_variable));
                check_field("coded_number", 64'(want.fields.coded_number),
                            64'(got.coded_number));
                check_field("block_size", 64'(want.fields.block_size),
                            64'(got.block_size));
                check_field("sample_rate", 64'(want.fields.sample_rate),
                            64'(got.sample_rate));
                check_field("channel_assignment", 64'(want.fields.channel_assignment),
                            64'(got.channel_assignment));
                check_field("channel_mode", 64'(want.fields.channel_mode),
                            64'(got.channel_mode));
                check_field("num_channels", 64'(want.fields.num_channels),
                            64'(got.num_channels));
                check_field("sample_size", 64'(want.fields.sample_size),
                            64'(got.sample_size));
                check_field("crc_byte", 64'(want.fields.crc_byte), 64'(got.crc_byte));
                check_field("pad", 64'(want.fields.pad), 64'(got.pad));
            end
        end
    end

    // Watchdog: a long run of cycles with no beat taken on either side means
    // the block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: reset, stimulus, drain, verdict.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        fail_count    = 0;
        ignored_beats = 0;
        results_seen  = 0;
        idle_cycles   = 0;
        clear_parser();
        build_stimulus();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every beat has been taken and every header has come out.
        while (pending_beats.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_headers.size() != 0)
        begin
            @(posedge clk);
        end
        // Keep running for DRAIN_CYCLES so that any stray result beat is caught.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_headers.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
